@@ rtl/core/bde_pkg.sv @@
// Shared types, codes and constants for the bounded deque engine.
package bde_pkg;

    localparam int unsigned DEPTH_DEFAULT = 256;
    localparam int unsigned CAP_W         = 9;
    localparam int unsigned CNT_W         = 9;
    localparam int unsigned WORD_W        = 32;
    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    typedef enum logic [1:0] {
        OP_PUSH_BACK  = 2'd0,
        OP_PUSH_FRONT = 2'd1,
        OP_POP_BACK   = 2'd2,
        OP_POP_FRONT  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_code_t;

    typedef enum logic {
        S_IDLE  = 1'b0,
        S_FETCH = 1'b1
    } ctrl_state_t;

    // Controller to datapath.
    typedef struct packed {
        logic exec;     // execute the operation presented at the inputs
        logic finish;   // load the fetched back element and emit the result
    } bde_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic need_fetch;   // pop back leaves entries: new back comes from memory
    } bde_stat_t;

endpackage

@@ rtl/core/bde_ctrl.sv @@
// Controller state machine for the bounded deque engine.
module bde_ctrl
    import bde_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  bde_stat_t stat,
    output bde_cmd_t  cmd,
    output logic      busy
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.exec = 1'b1;
                    if (stat.need_fetch)
                    begin
                        state_next = S_FETCH;
                    end
                end
            end
            S_FETCH:
            begin
                // hold off new work while the memory read lands
                busy       = 1'b1;
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/bde_datapath.sv @@
// Ring storage, pointers, count and result registers of the bounded deque engine.
module bde_datapath
    import bde_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  bde_cmd_t          cmd,
    output bde_stat_t         stat,
    input  logic [1:0]        opcode,
    input  logic [WORD_W-1:0] push_value,
    input  logic [CAP_W-1:0]  cap,
    output logic              done,
    output logic [1:0]        status,
    output logic [CNT_W-1:0]  entry_count,
    output logic [WORD_W-1:0] back_value
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    logic [PW-1:0]     front_reg, front_next;
    logic [PW-1:0]     back_ptr_reg, back_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [WORD_W-1:0] back_reg, back_next;

    logic              done_reg;
    logic [1:0]        status_reg;
    logic [CNT_W-1:0]  count_out_reg;
    logic [WORD_W-1:0] back_out_reg;

    logic [PW-1:0]     front_inc, front_dec, back_inc, back_dec;
    logic              is_full, is_empty;
    logic              wr_en;
    logic [PW-1:0]     wr_addr;
    status_code_t      st;
    opcode_t           op;

    assign op        = opcode_t'(opcode);
    assign front_inc = (front_reg == LAST) ? '0 : front_reg + 1'b1;
    assign front_dec = (front_reg == '0) ? LAST : front_reg - 1'b1;
    assign back_inc  = (back_ptr_reg == LAST) ? '0 : back_ptr_reg + 1'b1;
    assign back_dec  = (back_ptr_reg == '0) ? LAST : back_ptr_reg - 1'b1;

    // limit is the smaller of the capacity register and the ring depth
    assign is_full  = (count_reg >= cap) || (32'(count_reg) >= DEPTH);
    assign is_empty = (count_reg == '0);

    assign stat.need_fetch = (op == OP_POP_BACK) && (count_reg > CNT_W'(1));

    always_comb
    begin
        front_next    = front_reg;
        back_ptr_next = back_ptr_reg;
        count_next    = count_reg;
        back_next     = back_reg;
        wr_en         = 1'b0;
        wr_addr       = back_inc;
        st            = ST_DONE;
        if (cmd.exec)
        begin
            case (op)
                OP_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        st = ST_FULL;
                    end
                    else
                    begin
                        wr_en         = 1'b1;
                        wr_addr       = back_inc;
                        back_ptr_next = back_inc;
                        count_next    = count_reg + 1'b1;
                        back_next     = push_value;
                    end
                end
                OP_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        st = ST_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = front_dec;
                        front_next = front_dec;
                        count_next = count_reg + 1'b1;
                        if (is_empty)
                        begin
                            back_next = push_value;
                        end
                    end
                end
                OP_POP_BACK:
                begin
                    if (is_empty)
                    begin
                        st = ST_EMPTY;
                    end
                    else
                    begin
                        back_ptr_next = back_dec;
                        count_next    = count_reg - 1'b1;
                    end
                end
                OP_POP_FRONT:
                begin
                    if (is_empty)
                    begin
                        st = ST_EMPTY;
                    end
                    else
                    begin
                        front_next = front_inc;
                        count_next = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    st = ST_DONE;
                end
            endcase
        end
        if (cmd.finish)
        begin
            back_next = rd_data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= push_value;
        end
        if (cmd.exec && stat.need_fetch)
        begin
            rd_data_reg <= mem[back_dec];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg    <= '0;
            back_ptr_reg <= LAST;
            count_reg    <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            front_reg    <= front_next;
            back_ptr_reg <= back_ptr_next;
            count_reg    <= count_next;
            done_reg     <= (cmd.exec && !stat.need_fetch) || cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        back_reg <= back_next;
        if (cmd.exec && !stat.need_fetch)
        begin
            status_reg    <= st;
            count_out_reg <= count_next;
            back_out_reg  <= (count_next == '0) ? '0 : back_next;
        end
        else if (cmd.finish)
        begin
            status_reg    <= ST_DONE;
            count_out_reg <= count_reg;
            back_out_reg  <= rd_data_reg;
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign entry_count = count_out_reg;
    assign back_value  = back_out_reg;

endmodule

@@ rtl/core/bounded_deque_engine_unit.sv @@
// Top level of the bounded deque engine: capacity register, controller and datapath.
//
// Bounded double-ended queue of 32-bit words held in a ring of DEPTH entries.
// Command channel: present opcode and push_value with start high; the
// transaction is taken at a rising edge where start is high and busy is low.
// Result channel: done pulses for one cycle with status, entry_count and
// back_value; the receiver cannot stall, so take the result in that cycle.
// Pushes, pops from the front, refused operations and a pop from the back that
// empties the deque give done in the cycle after the accepting edge. A pop from
// the back that leaves one or more entries first reads the new back element
// from the single read port of the ring memory into a register, with busy
// high while it does, and gives done once that read has landed.
// Throughput: one transaction per cycle while busy is low; busy holds off
// new transactions during such pops from the back.
// Configuration: one write channel (cfg_valid, cfg_ready, capacity_in_use)
// sets the entry limit; write it only while no transaction is in flight.
// Reset: empties the deque, front pointer 0, back pointer LAST, limit 256.
// The ring memory is not cleared; only written entries are ever read.
module bounded_deque_engine_unit
    import bde_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               opcode,
    input  logic signed [WORD_W-1:0] push_value,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CAP_W-1:0]         capacity_in_use,
    output logic                     done,
    output logic [1:0]               status,
    output logic [CNT_W-1:0]         entry_count,
    output logic signed [WORD_W-1:0] back_value
);

    bde_cmd_t          cmd;
    bde_stat_t         stat;
    logic [CAP_W-1:0]  cap_reg;
    logic [WORD_W-1:0] back_word;

    // Accept configuration whenever no fetch is pending.
    assign cfg_ready = !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cap_reg <= capacity_in_use;
        end
    end

    bde_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    bde_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .opcode      (opcode),
        .push_value  (push_value),
        .cap         (cap_reg),
        .done        (done),
        .status      (status),
        .entry_count (entry_count),
        .back_value  (back_word)
    );

    assign back_value = $signed(back_word);

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the bounded deque engine: directed and random deque transactions.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bde_pkg::*;

    localparam int unsigned CLK_HALF     = 5;
    localparam int unsigned RESET_CYCLES = 12;
    localparam int unsigned IDLE_PERCENT = 23;
    localparam int unsigned MAX_GAP      = 4;
    // Slowest correct case: a pop from the back that fetches, plus the longest sender gap,
    // so reaching STALL_LIMIT without any transaction can only mean a hang.
    localparam int unsigned STALL_LIMIT  = 5000;
    localparam int unsigned PTR_W        = $clog2(DEPTH_DEFAULT);

    // One expected result of the engine, as it should appear on the result ports.
    typedef struct packed {
        status_code_t      status;
        logic [CNT_W-1:0]  count;
        logic [WORD_W-1:0] back;
    } deque_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [1:0]               opcode;
    logic signed [WORD_W-1:0] push_value;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CAP_W-1:0]         capacity_in_use;
    logic                     done;
    logic [1:0]               status;
    logic [CNT_W-1:0]         entry_count;
    logic signed [WORD_W-1:0] back_value;

    // Shadow copy of the deque: ring of words, front index, fill level, limit.
    logic [WORD_W-1:0] shadow_ring [DEPTH_DEFAULT];
    logic [PTR_W-1:0]  shadow_front;
    logic [CNT_W-1:0]  shadow_held;
    logic [CAP_W-1:0]  shadow_cap;

    deque_result_t expected_results [$];
    int unsigned   mismatches;
    int unsigned   stall_cycles;
    bit            start_held;  // start left high after the last transaction
    bit            no_idle;     // suppress sender gaps for a stretch

    always #CLK_HALF clk = ~clk;

    bounded_deque_engine_unit #(
        .DEPTH(DEPTH_DEFAULT)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .push_value     (push_value),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .capacity_in_use(capacity_in_use),
        .done           (done),
        .status         (status),
        .entry_count    (entry_count),
        .back_value     (back_value)
    );

    // Apply one accepted operation to the shadow deque and queue the result it must give.
    task automatic predict_deque_op(opcode_t op, logic [WORD_W-1:0] word);
        deque_result_t    res;
        logic [CNT_W-1:0] limit;
        logic [PTR_W-1:0] slot;
        // A limit above the ring depth saturates at the depth.
        limit = (shadow_cap > CNT_W'(DEPTH_DEFAULT)) ? CNT_W'(DEPTH_DEFAULT) : shadow_cap;
        res.status = ST_DONE;
        case (op)
            OP_PUSH_BACK, OP_PUSH_FRONT:
            begin
                if (shadow_held >= limit)
                begin
                    res.status = ST_FULL;
                end
                else if (op == OP_PUSH_BACK)
                begin
                    slot = shadow_front + PTR_W'(shadow_held);
                    shadow_ring[slot] = word;
                    shadow_held++;
                end
                else
                begin
                    // Step the front index back one slot, wrapping below zero.
                    shadow_front = shadow_front - 1'b1;
                    shadow_ring[shadow_front] = word;
                    shadow_held++;
                end
            end
            default:
            begin
                if (shadow_held == 0)
                begin
                    res.status = ST_EMPTY;
                end
                else if (op == OP_POP_BACK)
                begin
                    shadow_held--;
                end
                else
                begin
                    shadow_front = shadow_front + 1'b1;
                    shadow_held--;
                end
            end
        endcase
        res.count = shadow_held;
        slot = shadow_front + PTR_W'(shadow_held - 1'b1);
        res.back = (shadow_held != 0) ? shadow_ring[slot] : '0;
        expected_results.push_back(res);
    endtask

    // Present one operation, hold it until the engine takes it, then maybe idle.
    task automatic send_op(opcode_t op, logic [WORD_W-1:0] word);
        int unsigned gap;
        start      <= 1'b1;
        opcode     <= op;
        push_value <= word;
        do @(posedge clk); while (busy !== 1'b0);
        predict_deque_op(op, word);
        // Lengthen the idle gap with the same odds at each step, up to MAX_GAP.
        gap = 0;
        while (!no_idle && gap < MAX_GAP && $urandom_range(99) < IDLE_PERCENT)
        begin
            gap++;
        end
        start_held = (gap == 0);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop start and wait until every issued transaction has produced its result.
    task automatic wait_idle();
        if (start_held)
        begin
            start <= 1'b0;
        end
        start_held = 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        // Let the engine settle after the last result before touching the register.
        repeat (3) @(posedge clk);
    endtask

    // Write the capacity register through its own channel while the engine is idle.
    task automatic write_capacity(logic [CAP_W-1:0] value);
        wait_idle();
        cfg_valid       <= 1'b1;
        capacity_in_use <= value;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        shadow_cap = value;
        cfg_valid <= 1'b0;
    endtask

    // Pops on an empty deque are refused from either end.
    task automatic test_empty_refusals();
        send_op(OP_POP_BACK, 32'h1234_5678);
        send_op(OP_POP_FRONT, 32'hFFFF_FFFF);
    endtask

    // Extreme words at both ends, then pops that take the fetch path and the short path.
    task automatic test_both_ends();
        send_op(OP_PUSH_BACK, 32'h7FFF_FFFF);
        send_op(OP_PUSH_FRONT, 32'h8000_0000);
        send_op(OP_PUSH_BACK, 32'hFFFF_FFFF);
        send_op(OP_PUSH_FRONT, 32'h0000_0000);
        send_op(OP_POP_BACK, 32'hDEAD_BEEF);
        send_op(OP_POP_FRONT, 32'h0);
        send_op(OP_POP_BACK, 32'h0);
        send_op(OP_POP_BACK, 32'h0);
    endtask

    // Small limits, a zero limit, and a limit lowered below the fill level.
    task automatic test_capacity_limits();
        write_capacity(CAP_W'(2));
        send_op(OP_PUSH_BACK, 32'h0000_0001);
        send_op(OP_PUSH_FRONT, 32'h0000_0002);
        send_op(OP_PUSH_BACK, 32'h0000_0003);
        send_op(OP_POP_FRONT, 32'h0);
        // Zero limit: every push is refused, pops still work.
        write_capacity(CAP_W'(0));
        send_op(OP_PUSH_FRONT, 32'h0000_0004);
        send_op(OP_POP_BACK, 32'h0);
        send_op(OP_PUSH_BACK, 32'h0000_0005);
        write_capacity(CAP_W'(3));
        send_op(OP_PUSH_BACK, 32'hA5A5_A5A5);
        send_op(OP_PUSH_BACK, 32'h5A5A_5A5A);
        send_op(OP_PUSH_BACK, 32'hC3C3_C3C3);
        // Limit now below the count: entries stay, pushes refused until pops catch up.
        write_capacity(CAP_W'(1));
        send_op(OP_PUSH_FRONT, 32'h0000_0006);
        send_op(OP_POP_BACK, 32'h0);
        send_op(OP_POP_FRONT, 32'h0);
        send_op(OP_PUSH_BACK, 32'h0000_0007);
        send_op(OP_POP_BACK, 32'h0);
        send_op(OP_PUSH_BACK, 32'h0000_0008);
        send_op(OP_POP_FRONT, 32'h0);
    endtask

    // Fill the whole ring with a limit above the depth, refuse more, then drain half of it.
    task automatic test_fill_to_depth();
        write_capacity(CAP_W'(511));
        // Fill back to back with no sender gaps.
        no_idle = 1'b1;
        repeat (DEPTH_DEFAULT + 2)
        begin
            send_op(opcode_t'($urandom_range(0, 1)), $urandom());
        end
        no_idle = 1'b0;
        // Lower the limit while full; pushes must stay refused.
        write_capacity(CAP_W'(100));
        send_op(OP_PUSH_BACK, $urandom());
        repeat (DEPTH_DEFAULT / 2)
        begin
            send_op(opcode_t'($urandom_range(2, 3)), $urandom());
        end
        write_capacity(CAP_RESET);
    endtask

    // Random transactions over a sweep of limits, alternating fill-biased and drain-biased phases.
    task automatic test_random_mix();
        int unsigned limits [11];
        int unsigned push_bias;
        int unsigned lim;
        limits = '{1, 2, 5, 33, 128, 255, 256, 257, 511, 0, 0};
        for (int ph = 0; ph < 11; ph++)
        begin
            lim = (ph == 10) ? $urandom_range(1, DEPTH_DEFAULT) : limits[ph];
            write_capacity(CAP_W'(lim));
            no_idle   = (ph == 6);
            push_bias = (ph % 2 == 0) ? 70 : 35;
            repeat (12)
            begin
                if ($urandom_range(99) < push_bias)
                begin
                    send_op(opcode_t'($urandom_range(0, 1)), $urandom());
                end
                else
                begin
                    send_op(opcode_t'($urandom_range(2, 3)), $urandom());
                end
            end
        end
        no_idle = 1'b0;
    endtask

    // Compare each result strobe against the oldest expectation, field by field.
    always @(posedge clk)
    begin
        deque_result_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result: status %0d count %0d back %h",
                         $time, status, entry_count, back_value);
            end
            else
            begin
                want = expected_results.pop_front();
                if (status !== want.status)
                begin
                    mismatches++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, status);
                end
                if (entry_count !== want.count)
                begin
                    mismatches++;
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, want.count, entry_count);
                end
                if (back_value !== want.back)
                begin
                    mismatches++;
                    $display("%0t: back_value expected %h actual %h",
                             $time, want.back, back_value);
                end
            end
        end
    end

    // Watchdog: end the run if no transaction moves on any channel for too long.
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (start && !busy) || done || (cfg_valid && cfg_ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d results outstanding",
                     $time, expected_results.size());
            $display("Simulation FAILED");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        // Drive every input to a known value and hold reset.
        rst_n           = 1'b0;
        start           = 1'b0;
        opcode          = OP_PUSH_BACK;
        push_value      = '0;
        cfg_valid       = 1'b0;
        capacity_in_use = CAP_RESET;
        mismatches      = 0;
        stall_cycles    = 0;
        start_held      = 1'b0;
        no_idle         = 1'b0;
        shadow_front    = '0;
        shadow_held     = '0;
        shadow_cap      = CAP_RESET;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_refusals();
        test_both_ends();
        test_capacity_limits();
        test_fill_to_depth();
        test_random_mix();

        // Drain the last results, then wait on for any stray strobe before the verdict.
        wait_idle();
        repeat (5) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
